### rtl/blps_pkg.sv
// Package: shared types, codes and fixed step tables for the buzzer/LED sequencer.
`timescale 1ns / 1ps
`default_nettype none

package blps_pkg;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_MODE   = 2'd1,
        ACT_REMOTE = 2'd2
    } action_t;

    localparam logic [2:0] MODE_INIT    = 3'd0;
    localparam logic [2:0] MODE_ERROR   = 3'd1;
    localparam logic [2:0] MODE_SAFE    = 3'd2;
    localparam logic [2:0] MODE_STANDBY = 3'd3;
    localparam logic [2:0] MODE_NORMAL  = 3'd4;

    localparam logic [1:0] BUZ_NONE = 2'd0;
    localparam logic [1:0] BUZ_SET  = 2'd1;
    localparam logic [1:0] BUZ_OFF  = 2'd2;

    localparam logic [1:0] LED_NONE    = 2'd0;
    localparam logic [1:0] LED_STATIC  = 2'd1;
    localparam logic [1:0] LED_BREATHE = 2'd2;
    localparam logic [1:0] LED_OFF     = 2'd3;

    typedef enum logic [2:0] {
        PAT_NONE    = 3'd0,
        PAT_INIT    = 3'd1,
        PAT_HINT    = 3'd2,
        PAT_LOST    = 3'd3,
        PAT_RECOVER = 3'd4,
        PAT_ERROR   = 3'd5
    } pat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD,
        ST_GEN,
        ST_READ,
        ST_SHOW,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [15:0] freq;
        logic [9:0]  dur;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } step_t;

    localparam int STEP_W = $bits(step_t);

    localparam logic [15:0] ERR_BEEP_FREQ = 16'd3000;
    localparam logic [9:0]  ERR_BEEP_DUR  = 10'd80;
    localparam logic [9:0]  ERR_GAP_DUR   = 10'd60;
    localparam logic [9:0]  ERR_LAST_DUR  = 10'd800;
    localparam logic [9:0]  ERR_IDLE_DUR  = 10'd500;

    function automatic step_t mk_step(input logic [15:0] f, input logic [9:0] d,
                                      input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
        step_t s;
        s.freq  = f;
        s.dur   = d;
        s.red   = r;
        s.green = g;
        s.blue  = b;
        return s;
    endfunction

    function automatic logic [2:0] tab_len(input pat_t pat);
        logic [2:0] n;
        case (pat)
            PAT_INIT:    n = 3'd5;
            PAT_HINT:    n = 3'd3;
            PAT_LOST:    n = 3'd3;
            PAT_RECOVER: n = 3'd3;
            default:     n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic step_t tab_step(input pat_t pat, input logic [2:0] idx);
        step_t s;
        s = '0;
        case (pat)
            PAT_INIT:
            begin
                case (idx)
                    3'd0:    s = mk_step(16'd880,  10'd170, 8'd255, 8'd0,   8'd0);
                    3'd1:    s = mk_step(16'd0,    10'd50,  8'd255, 8'd0,   8'd0);
                    3'd2:    s = mk_step(16'd1100, 10'd170, 8'd0,   8'd0,   8'd255);
                    3'd3:    s = mk_step(16'd0,    10'd50,  8'd0,   8'd0,   8'd255);
                    3'd4:    s = mk_step(16'd1320, 10'd300, 8'd0,   8'd255, 8'd0);
                    default: s = '0;
                endcase
            end
            PAT_HINT:
            begin
                case (idx)
                    3'd0:    s = mk_step(16'd2500, 10'd120, 8'd0, 8'd255, 8'd0);
                    3'd1:    s = mk_step(16'd0,    10'd20,  8'd0, 8'd0,   8'd0);
                    3'd2:    s = mk_step(16'd3000, 10'd180, 8'd0, 8'd255, 8'd0);
                    default: s = '0;
                endcase
            end
            PAT_LOST:
            begin
                case (idx)
                    3'd0:    s = mk_step(16'd1500, 10'd200, 8'd0, 8'd0, 8'd255);
                    3'd1:    s = mk_step(16'd0,    10'd50,  8'd0, 8'd0, 8'd0);
                    3'd2:    s = mk_step(16'd1500, 10'd200, 8'd0, 8'd0, 8'd255);
                    default: s = '0;
                endcase
            end
            PAT_RECOVER:
            begin
                case (idx)
                    3'd0:    s = mk_step(16'd2500, 10'd150, 8'd0, 8'd0,   8'd255);
                    3'd1:    s = mk_step(16'd0,    10'd40,  8'd0, 8'd0,   8'd0);
                    3'd2:    s = mk_step(16'd3000, 10'd150, 8'd0, 8'd255, 8'd0);
                    default: s = '0;
                endcase
            end
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### rtl/buzzer_led_pattern_sequencer.sv
// Top level: buzzer and status-LED pattern sequencer.
//
// One beat in, one result out. A tick or an event that starts nothing goes from EXEC
// straight to done; a tick that moves to the next step also passes READ and SHOW, as
// the step is fetched from the step RAM through its registered read port. Starting a
// fixed pattern writes its steps into the RAM one per cycle in LOAD before READ and
// SHOW. The error pattern is generated in GEN by one counter/compare sequencer that
// writes its beep and gap steps one per cycle, pausing to check each module, to
// stretch a group's last step and to skip a faulty group's remaining pairs when the
// store is full.
// busy is high from the accepted beat until the result.
// done is high for exactly one cycle with the result fields; the receiver cannot stall
// and the fields are only meaningful in that cycle.
`timescale 1ns / 1ps
`default_nettype none

module buzzer_led_pattern_sequencer #(
    parameter int STEP_DEPTH = 32,
    parameter int MODULES    = 5
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  action,
    input  wire logic [2:0]  mode,
    input  wire logic [4:0]  error_bits,
    input  wire logic        imu_preparing,
    input  wire logic        online,
    output logic             done,
    output logic      [1:0]  buzzer_cmd,
    output logic      [15:0] buzzer_freq,
    output logic      [1:0]  led_cmd,
    output logic      [7:0]  led_red,
    output logic      [7:0]  led_green,
    output logic      [7:0]  led_blue,
    output logic             playing
);

    localparam int AW    = $clog2(STEP_DEPTH);
    localparam int CNT_W = $clog2(STEP_DEPTH + 1);
    localparam int MOD_W = $clog2(MODULES + 1);
    localparam logic [CNT_W-1:0] GEN_LIMIT = CNT_W'(STEP_DEPTH - 2);

    blps_pkg::state_t state_reg, state_next;
    blps_pkg::pat_t   pat_reg, pat_next;

    logic             running_reg, running_next;
    logic [9:0]       timer_reg, timer_next;
    logic [CNT_W-1:0] index_reg, index_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [MOD_W-1:0] mod_reg, mod_next;
    logic [MOD_W-1:0] pair_reg, pair_next;
    logic             phase_reg, phase_next;
    logic [AW-1:0]    raddr_reg, raddr_next;

    logic [1:0]       act_reg, act_next;
    logic [2:0]       mode_reg, mode_next;
    logic [4:0]       bits_reg, bits_next;
    logic             imu_reg, imu_next;
    logic             online_reg, online_next;

    logic [1:0]       bcmd_reg, bcmd_next;
    logic [15:0]      freq_reg, freq_next;
    logic [1:0]       lcmd_reg, lcmd_next;
    logic [7:0]       red_reg, red_next;
    logic [7:0]       green_reg, green_next;
    logic [7:0]       blue_reg, blue_next;

    logic                 we;
    logic [AW-1:0]        waddr;
    blps_pkg::step_t      wstep;
    logic                 re;
    logic [blps_pkg::STEP_W-1:0] rdata;
    blps_pkg::step_t      rstep;

    logic             try_start;
    blps_pkg::pat_t   start_id;
    logic [CNT_W-1:0] index_inc;
    logic [CNT_W-1:0] n_dec;
    logic [CNT_W-1:0] load_last;
    logic             muted;
    logic             breathe_evt;

    blps_step_ram #(
        .DEPTH (STEP_DEPTH),
        .AW    (AW),
        .DW    (blps_pkg::STEP_W)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wstep),
        .re    (re),
        .raddr (raddr_reg),
        .rdata (rdata)
    );

    assign rstep       = blps_pkg::step_t'(rdata);
    assign index_inc   = index_reg + CNT_W'(1);
    assign n_dec       = n_reg - CNT_W'(1);
    assign load_last   = CNT_W'(blps_pkg::tab_len(pat_reg)) - CNT_W'(1);
    assign muted       = imu_reg && (mode_reg != blps_pkg::MODE_INIT);
    assign breathe_evt = (act_reg == blps_pkg::ACT_MODE) && (mode_reg == blps_pkg::MODE_NORMAL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= blps_pkg::ST_IDLE;
            pat_reg     <= blps_pkg::PAT_NONE;
            running_reg <= 1'b0;
            timer_reg   <= '0;
            index_reg   <= '0;
            total_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pat_reg     <= pat_next;
            running_reg <= running_next;
            timer_reg   <= timer_next;
            index_reg   <= index_next;
            total_reg   <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        mod_reg    <= mod_next;
        pair_reg   <= pair_next;
        phase_reg  <= phase_next;
        raddr_reg  <= raddr_next;
        act_reg    <= act_next;
        mode_reg   <= mode_next;
        bits_reg   <= bits_next;
        imu_reg    <= imu_next;
        online_reg <= online_next;
        bcmd_reg   <= bcmd_next;
        freq_reg   <= freq_next;
        lcmd_reg   <= lcmd_next;
        red_reg    <= red_next;
        green_reg  <= green_next;
        blue_reg   <= blue_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        pat_next     = pat_reg;
        running_next = running_reg;
        timer_next   = timer_reg;
        index_next   = index_reg;
        total_next   = total_reg;
        n_next       = n_reg;
        mod_next     = mod_reg;
        pair_next    = pair_reg;
        phase_next   = phase_reg;
        raddr_next   = raddr_reg;
        act_next     = act_reg;
        mode_next    = mode_reg;
        bits_next    = bits_reg;
        imu_next     = imu_reg;
        online_next  = online_reg;
        bcmd_next    = bcmd_reg;
        freq_next    = freq_reg;
        lcmd_next    = lcmd_reg;
        red_next     = red_reg;
        green_next   = green_reg;
        blue_next    = blue_reg;
        we           = 1'b0;
        waddr        = n_reg[AW-1:0];
        wstep        = '0;
        re           = 1'b0;
        try_start    = 1'b0;
        start_id     = blps_pkg::PAT_NONE;

        case (state_reg)
            blps_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    act_next    = action;
                    mode_next   = mode;
                    bits_next   = error_bits;
                    imu_next    = imu_preparing;
                    online_next = online;
                    bcmd_next   = blps_pkg::BUZ_NONE;
                    freq_next   = '0;
                    lcmd_next   = blps_pkg::LED_NONE;
                    red_next    = '0;
                    green_next  = '0;
                    blue_next   = '0;
                    state_next  = blps_pkg::ST_EXEC;
                end
            end

            blps_pkg::ST_EXEC:
            begin
                state_next = blps_pkg::ST_DONE;
                case (act_reg)
                    blps_pkg::ACT_TICK:
                    begin
                        if (muted)
                        begin
                            bcmd_next = blps_pkg::BUZ_OFF;
                        end
                        if (!running_reg && (mode_reg == blps_pkg::MODE_INIT))
                        begin
                            lcmd_next = blps_pkg::LED_OFF;
                        end
                        if (running_reg)
                        begin
                            if (timer_reg != 10'd0)
                            begin
                                timer_next = timer_reg - 10'd1;
                            end
                            else if (index_inc < total_reg)
                            begin
                                index_next = index_inc;
                                raddr_next = index_inc[AW-1:0];
                                state_next = blps_pkg::ST_READ;
                            end
                            else
                            begin
                                index_next   = index_inc;
                                bcmd_next    = blps_pkg::BUZ_OFF;
                                running_next = 1'b0;
                                pat_next     = blps_pkg::PAT_NONE;
                                if (mode_reg == blps_pkg::MODE_NORMAL)
                                begin
                                    lcmd_next  = blps_pkg::LED_BREATHE;
                                    green_next = 8'd255;
                                end
                                else
                                begin
                                    lcmd_next = blps_pkg::LED_STATIC;
                                end
                            end
                        end
                    end
                    blps_pkg::ACT_MODE:
                    begin
                        case (mode_reg)
                            blps_pkg::MODE_INIT:
                            begin
                                try_start = 1'b1;
                                start_id  = blps_pkg::PAT_INIT;
                            end
                            blps_pkg::MODE_ERROR, blps_pkg::MODE_SAFE:
                            begin
                                try_start = 1'b1;
                                start_id  = blps_pkg::PAT_ERROR;
                            end
                            blps_pkg::MODE_STANDBY:
                            begin
                                try_start = 1'b1;
                                start_id  = blps_pkg::PAT_LOST;
                            end
                            blps_pkg::MODE_NORMAL:
                            begin
                                try_start  = !running_reg;
                                start_id   = blps_pkg::PAT_HINT;
                                lcmd_next  = blps_pkg::LED_BREATHE;
                                green_next = 8'd255;
                            end
                            default:
                            begin
                                try_start = 1'b0;
                            end
                        endcase
                    end
                    blps_pkg::ACT_REMOTE:
                    begin
                        try_start = online_reg;
                        start_id  = blps_pkg::PAT_RECOVER;
                    end
                    default:
                    begin
                        try_start = 1'b0;
                    end
                endcase

                if (try_start && !(running_reg && (pat_reg == start_id)))
                begin
                    pat_next   = start_id;
                    n_next     = '0;
                    mod_next   = '0;
                    pair_next  = '0;
                    phase_next = 1'b0;
                    if (start_id == blps_pkg::PAT_ERROR)
                    begin
                        state_next = blps_pkg::ST_GEN;
                    end
                    else
                    begin
                        state_next = blps_pkg::ST_LOAD;
                    end
                end
            end

            blps_pkg::ST_LOAD:
            begin
                we     = 1'b1;
                wstep  = blps_pkg::tab_step(pat_reg, n_reg[2:0]);
                n_next = n_reg + CNT_W'(1);
                if (n_reg == load_last)
                begin
                    total_next   = n_next;
                    index_next   = '0;
                    running_next = 1'b1;
                    raddr_next   = '0;
                    state_next   = blps_pkg::ST_READ;
                end
            end

            blps_pkg::ST_GEN:
            begin
                if (mod_reg == MOD_W'(MODULES))
                begin
                    if (n_reg == '0 || phase_reg)
                    begin
                        // no fault: yellow beep then silence
                        we         = 1'b1;
                        waddr      = phase_reg ? AW'(1) : AW'(0);
                        phase_next = !phase_reg;
                        if (phase_reg)
                        begin
                            wstep  = blps_pkg::mk_step(16'd0, blps_pkg::ERR_IDLE_DUR,
                                                       8'd0, 8'd0, 8'd0);
                            n_next = CNT_W'(2);
                        end
                        else
                        begin
                            wstep  = blps_pkg::mk_step(blps_pkg::ERR_BEEP_FREQ,
                                                       blps_pkg::ERR_IDLE_DUR,
                                                       8'd255, 8'd200, 8'd0);
                        end
                    end
                    else
                    begin
                        total_next   = n_reg;
                        index_next   = '0;
                        running_next = 1'b1;
                        raddr_next   = '0;
                        state_next   = blps_pkg::ST_READ;
                    end
                end
                else if (!bits_reg[mod_reg])
                begin
                    mod_next = mod_reg + MOD_W'(1);
                end
                else if ((pair_reg <= mod_reg) && (n_reg < GEN_LIMIT))
                begin
                    we = 1'b1;
                    if (phase_reg)
                    begin
                        waddr      = n_reg[AW-1:0] + AW'(1);
                        wstep      = blps_pkg::mk_step(16'd0, blps_pkg::ERR_GAP_DUR,
                                                       8'd0, 8'd0, 8'd0);
                        n_next     = n_reg + CNT_W'(2);
                        pair_next  = pair_reg + MOD_W'(1);
                        phase_next = 1'b0;
                    end
                    else
                    begin
                        wstep      = blps_pkg::mk_step(blps_pkg::ERR_BEEP_FREQ,
                                                       blps_pkg::ERR_BEEP_DUR,
                                                       8'd255, 8'd0, 8'd0);
                        phase_next = 1'b1;
                    end
                end
                else if ((pair_reg <= mod_reg) && phase_reg == 1'b0)
                begin
                    // store full: skip the remaining pairs of this group
                    pair_next = mod_reg + MOD_W'(1);
                end
                else
                begin
                    // group end: stretch the last step so far
                    we        = (n_reg != '0);
                    waddr     = n_dec[AW-1:0];
                    wstep     = blps_pkg::mk_step(16'd0, blps_pkg::ERR_LAST_DUR,
                                                  8'd0, 8'd0, 8'd0);
                    mod_next  = mod_reg + MOD_W'(1);
                    pair_next = '0;
                end
            end

            blps_pkg::ST_READ:
            begin
                re         = 1'b1;
                state_next = blps_pkg::ST_SHOW;
            end

            blps_pkg::ST_SHOW:
            begin
                timer_next = rstep.dur;
                if (muted)
                begin
                    bcmd_next = blps_pkg::BUZ_OFF;
                    freq_next = '0;
                end
                else
                begin
                    bcmd_next = blps_pkg::BUZ_SET;
                    freq_next = rstep.freq;
                end
                if (!breathe_evt)
                begin
                    lcmd_next  = blps_pkg::LED_STATIC;
                    red_next   = rstep.red;
                    green_next = rstep.green;
                    blue_next  = rstep.blue;
                end
                state_next = blps_pkg::ST_DONE;
            end

            blps_pkg::ST_DONE:
            begin
                state_next = blps_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = blps_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != blps_pkg::ST_IDLE);
    assign done        = (state_reg == blps_pkg::ST_DONE);
    assign buzzer_cmd  = bcmd_reg;
    assign buzzer_freq = freq_reg;
    assign led_cmd     = lcmd_reg;
    assign led_red     = red_reg;
    assign led_green   = green_reg;
    assign led_blue    = blue_reg;
    assign playing     = running_reg;

endmodule

`default_nettype wire

### rtl/blps_step_ram.sv
// Step store: single write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module blps_step_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 50
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### tb/buzzer_led_pattern_sequencer_test.sv
// Testbench for the buzzer/LED pattern sequencer: directed and random beats against a predictor.
`timescale 1ns / 1ps

module buzzer_led_pattern_sequencer_test;

    localparam int STEP_DEPTH = 32;
    localparam int MODULES    = 5;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [2:0] MODE_OTHER = 3'd5;
    localparam logic [2:0] MODE_LAST  = 3'd7;
    localparam int DRAIN_CYCLES  = 60;
    localparam int RECOVER_TICKS = 344;

    typedef struct packed {
        logic [1:0]  bcmd;
        logic [15:0] freq;
        logic [1:0]  lcmd;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        playing;
    } cmd_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  action;
    logic [2:0]  mode;
    logic [4:0]  error_bits;
    logic        imu_preparing;
    logic        online;
    logic        done;
    logic [1:0]  buzzer_cmd;
    logic [15:0] buzzer_freq;
    logic [1:0]  led_cmd;
    logic [7:0]  led_red;
    logic [7:0]  led_green;
    logic [7:0]  led_blue;
    logic        playing;

    buzzer_led_pattern_sequencer #(
        .STEP_DEPTH(STEP_DEPTH),
        .MODULES   (MODULES)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .mode         (mode),
        .error_bits   (error_bits),
        .imu_preparing(imu_preparing),
        .online       (online),
        .done         (done),
        .buzzer_cmd   (buzzer_cmd),
        .buzzer_freq  (buzzer_freq),
        .led_cmd      (led_cmd),
        .led_red      (led_red),
        .led_green    (led_green),
        .led_blue     (led_blue),
        .playing      (playing)
    );

    // sequencer state as the predictor sees it
    logic            seq_running;
    int              seq_timer;
    int              seq_index;
    int              seq_total;
    blps_pkg::pat_t  seq_pat;
    blps_pkg::step_t seq_steps [STEP_DEPTH];
    blps_pkg::step_t staged [STEP_DEPTH];
    int              staged_len;
    cmd_t            outcome;

    cmd_t  pending_cmds [$];
    int    mismatches;
    int    sender_idle_pct;
    logic [2:0] cur_mode;

    always #10 clk = ~clk;

    function automatic void emit_tone(input logic [15:0] f, input logic [2:0] md,
                                      input logic imu);
        if (imu && md != blps_pkg::MODE_INIT)
        begin
            outcome.bcmd = blps_pkg::BUZ_OFF;
            outcome.freq = '0;
        end
        else
        begin
            outcome.bcmd = blps_pkg::BUZ_SET;
            outcome.freq = f;
        end
    endfunction

    function automatic void emit_color(input blps_pkg::step_t s);
        outcome.lcmd  = blps_pkg::LED_STATIC;
        outcome.red   = s.red;
        outcome.green = s.green;
        outcome.blue  = s.blue;
    endfunction

    function automatic void emit_breathe();
        outcome.lcmd  = blps_pkg::LED_BREATHE;
        outcome.red   = 8'd0;
        outcome.green = 8'd255;
        outcome.blue  = 8'd0;
    endfunction

    function automatic void stage_fixed(input blps_pkg::pat_t p);
        case (p)
            blps_pkg::PAT_INIT:
            begin
                staged[0] = {16'd880,  10'd170, 8'd255, 8'd0,   8'd0};
                staged[1] = {16'd0,    10'd50,  8'd255, 8'd0,   8'd0};
                staged[2] = {16'd1100, 10'd170, 8'd0,   8'd0,   8'd255};
                staged[3] = {16'd0,    10'd50,  8'd0,   8'd0,   8'd255};
                staged[4] = {16'd1320, 10'd300, 8'd0,   8'd255, 8'd0};
                staged_len = 5;
            end
            blps_pkg::PAT_HINT:
            begin
                staged[0] = {16'd2500, 10'd120, 8'd0, 8'd255, 8'd0};
                staged[1] = {16'd0,    10'd20,  8'd0, 8'd0,   8'd0};
                staged[2] = {16'd3000, 10'd180, 8'd0, 8'd255, 8'd0};
                staged_len = 3;
            end
            blps_pkg::PAT_LOST:
            begin
                staged[0] = {16'd1500, 10'd200, 8'd0, 8'd0, 8'd255};
                staged[1] = {16'd0,    10'd50,  8'd0, 8'd0, 8'd0};
                staged[2] = {16'd1500, 10'd200, 8'd0, 8'd0, 8'd255};
                staged_len = 3;
            end
            default:
            begin
                staged[0] = {16'd2500, 10'd150, 8'd0, 8'd0,   8'd255};
                staged[1] = {16'd0,    10'd40,  8'd0, 8'd0,   8'd0};
                staged[2] = {16'd3000, 10'd150, 8'd0, 8'd255, 8'd0};
                staged_len = 3;
            end
        endcase
    endfunction

    // a pattern already playing is left alone
    function automatic void launch_staged(input blps_pkg::pat_t id, input logic [2:0] md,
                                          input logic imu);
        if (seq_running && seq_pat == id)
            return;
        for (int i = 0; i < staged_len; i++)
            seq_steps[i] = staged[i];
        seq_pat     = id;
        seq_total   = staged_len;
        seq_index   = 0;
        seq_running = 1'b1;
        seq_timer   = seq_steps[0].dur;
        emit_tone(seq_steps[0].freq, md, imu);
        emit_color(seq_steps[0]);
    endfunction

    function automatic void advance_sequencer(input logic [1:0] act, input logic [2:0] md,
                                              input logic [4:0] bits, input logic imu,
                                              input logic onl);
        blps_pkg::step_t beep;
        blps_pkg::step_t gap;
        int    n;
        beep = {blps_pkg::ERR_BEEP_FREQ, blps_pkg::ERR_BEEP_DUR, 8'd255, 8'd0, 8'd0};
        gap  = {16'd0, blps_pkg::ERR_GAP_DUR, 24'd0};
        n    = 0;
        outcome = '0;
        case (act)
            blps_pkg::ACT_TICK:
            begin
                if (imu && md != blps_pkg::MODE_INIT)
                begin
                    outcome.bcmd = blps_pkg::BUZ_OFF;
                    outcome.freq = '0;
                end
                if (!seq_running && md == blps_pkg::MODE_INIT)
                    outcome.lcmd = blps_pkg::LED_OFF;
                if (seq_running)
                begin
                    if (seq_timer > 0)
                        seq_timer--;
                    else
                    begin
                        seq_index++;
                        if (seq_index < seq_total && seq_index < STEP_DEPTH)
                        begin
                            seq_timer = seq_steps[seq_index].dur;
                            emit_tone(seq_steps[seq_index].freq, md, imu);
                            emit_color(seq_steps[seq_index]);
                        end
                        else
                        begin
                            outcome.bcmd = blps_pkg::BUZ_OFF;
                            outcome.freq = '0;
                            if (md == blps_pkg::MODE_NORMAL)
                                emit_breathe();
                            else
                                emit_color('0);
                            seq_running = 1'b0;
                            seq_pat     = blps_pkg::PAT_NONE;
                        end
                    end
                end
            end
            blps_pkg::ACT_MODE:
            begin
                case (md)
                    blps_pkg::MODE_INIT:
                    begin
                        stage_fixed(blps_pkg::PAT_INIT);
                        launch_staged(blps_pkg::PAT_INIT, md, imu);
                    end
                    blps_pkg::MODE_ERROR, blps_pkg::MODE_SAFE:
                    begin
                        for (int i = 0; i < MODULES; i++)
                        begin
                            if (bits[i])
                            begin
                                for (int k = 0; k <= i; k++)
                                begin
                                    if (n < STEP_DEPTH - 2)
                                    begin
                                        staged[n]     = beep;
                                        staged[n + 1] = gap;
                                        n += 2;
                                    end
                                end
                                if (n > 0)
                                    staged[n - 1].dur = blps_pkg::ERR_LAST_DUR;
                            end
                        end
                        if (n == 0)
                        begin
                            staged[0] = {blps_pkg::ERR_BEEP_FREQ, blps_pkg::ERR_IDLE_DUR,
                                         8'd255, 8'd200, 8'd0};
                            staged[1] = {16'd0, blps_pkg::ERR_IDLE_DUR, 24'd0};
                            n = 2;
                        end
                        staged_len = n;
                        launch_staged(blps_pkg::PAT_ERROR, md, imu);
                    end
                    blps_pkg::MODE_STANDBY:
                    begin
                        stage_fixed(blps_pkg::PAT_LOST);
                        launch_staged(blps_pkg::PAT_LOST, md, imu);
                    end
                    blps_pkg::MODE_NORMAL:
                    begin
                        if (!seq_running)
                        begin
                            stage_fixed(blps_pkg::PAT_HINT);
                            launch_staged(blps_pkg::PAT_HINT, md, imu);
                        end
                        emit_breathe();
                    end
                    default: ;
                endcase
            end
            blps_pkg::ACT_REMOTE:
            begin
                if (onl)
                begin
                    stage_fixed(blps_pkg::PAT_RECOVER);
                    launch_staged(blps_pkg::PAT_RECOVER, md, imu);
                end
            end
            default: ;
        endcase
        outcome.playing = seq_running;
        pending_cmds.push_back(outcome);
    endfunction

    task automatic send_beat(input logic [1:0] act, input logic [2:0] md,
                             input logic [4:0] bits, input logic imu, input logic onl);
        logic taken;
        taken = 1'b0;
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        start         <= 1'b1;
        action        <= act;
        mode          <= md;
        error_bits    <= bits;
        imu_preparing <= imu;
        online        <= onl;
        while (!taken)
        begin
            taken = !busy;
            @(negedge clk);
        end
        advance_sequencer(act, md, bits, imu, onl);
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_cmds.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got cmd %0d/%0d",
                         $time, buzzer_cmd, led_cmd);
            end
            else
            begin
                outcome = pending_cmds.pop_front();
                check_field("buzzer_cmd", outcome.bcmd, buzzer_cmd);
                check_field("buzzer_freq", outcome.freq, buzzer_freq);
                check_field("led_cmd", outcome.lcmd, led_cmd);
                check_field("led_red", outcome.red, led_red);
                check_field("led_green", outcome.green, led_green);
                check_field("led_blue", outcome.blue, led_blue);
                check_field("playing", outcome.playing, playing);
            end
        end
    end

    // idle ticks, unused codes and muting before any pattern runs
    task automatic test_idle_events();
        send_beat(blps_pkg::ACT_TICK, blps_pkg::MODE_INIT, 5'd0, 1'b0, 1'b0);
        send_beat(blps_pkg::ACT_TICK, blps_pkg::MODE_STANDBY, 5'h1f, 1'b1, 1'b1);
        send_beat(ACT_UNUSED, MODE_LAST, 5'h1f, 1'b1, 1'b1);
        for (int m = MODE_OTHER; m <= MODE_LAST; m++)
            send_beat(blps_pkg::ACT_MODE, 3'(m), 5'h15, 1'b0, 1'b0);
        send_beat(blps_pkg::ACT_REMOTE, blps_pkg::MODE_NORMAL, 5'd0, 1'b0, 1'b0);
    endtask

    task automatic test_fixed_patterns();
        send_beat(blps_pkg::ACT_MODE, blps_pkg::MODE_NORMAL, 5'd0, 1'b0, 1'b0);
        send_beat(blps_pkg::ACT_MODE, blps_pkg::MODE_NORMAL, 5'd0, 1'b0, 1'b0);
        send_beat(blps_pkg::ACT_MODE, blps_pkg::MODE_INIT, 5'd0, 1'b1, 1'b0);
        send_beat(blps_pkg::ACT_MODE, blps_pkg::MODE_INIT, 5'd0, 1'b0, 1'b0);
        send_beat(blps_pkg::ACT_MODE, blps_pkg::MODE_STANDBY, 5'd0, 1'b1, 1'b0);
        send_beat(blps_pkg::ACT_REMOTE, blps_pkg::MODE_STANDBY, 5'd0, 1'b0, 1'b1);
    endtask

    task automatic test_error_patterns();
        send_beat(blps_pkg::ACT_MODE, blps_pkg::MODE_ERROR, 5'd0, 1'b0, 1'b0);
        send_beat(blps_pkg::ACT_MODE, blps_pkg::MODE_SAFE, 5'h1f, 1'b0, 1'b0);
        send_beat(blps_pkg::ACT_MODE, blps_pkg::MODE_STANDBY, 5'd0, 1'b0, 1'b0);
        send_beat(blps_pkg::ACT_MODE, blps_pkg::MODE_SAFE, 5'h1f, 1'b0, 1'b0);
        send_beat(blps_pkg::ACT_MODE, blps_pkg::MODE_ERROR, 5'h10, 1'b0, 1'b0);
        send_beat(blps_pkg::ACT_REMOTE, blps_pkg::MODE_ERROR, 5'd0, 1'b0, 1'b1);
        send_beat(blps_pkg::ACT_MODE, blps_pkg::MODE_ERROR, 5'h01, 1'b0, 1'b0);
        send_beat(blps_pkg::ACT_REMOTE, blps_pkg::MODE_ERROR, 5'd0, 1'b0, 1'b1);
        send_beat(blps_pkg::ACT_MODE, blps_pkg::MODE_SAFE, 5'h10, 1'b1, 1'b0);
        for (int i = 0; i < 3; i++)
            send_beat(blps_pkg::ACT_TICK, blps_pkg::MODE_NORMAL, 5'd0, 1'b0, 1'b0);
    endtask

    // recover played to the end, then an idle tick in the init mode
    task automatic test_pattern_end();
        logic [2:0] md;
        send_beat(blps_pkg::ACT_REMOTE, blps_pkg::MODE_NORMAL, 5'd0, 1'b0, 1'b1);
        for (int t = 0; t < RECOVER_TICKS; t++)
        begin
            md = ($urandom_range(1) == 0) ? blps_pkg::MODE_NORMAL : blps_pkg::MODE_STANDBY;
            send_beat(blps_pkg::ACT_TICK, md, 5'($urandom), $urandom_range(15) == 0,
                      1'($urandom));
        end
        send_beat(blps_pkg::ACT_TICK, blps_pkg::MODE_INIT, 5'd0, 1'b1, 1'b0);
    endtask

    // an event followed by a short tick burst
    task automatic test_random_traffic(input int idle_pct, input int rounds);
        logic [1:0] act;
        logic [2:0] md;
        int         burst;
        sender_idle_pct = idle_pct;
        for (int r = 0; r < rounds; r++)
        begin
            if ($urandom_range(99) < 80)
            begin
                if ($urandom_range(5) == 0)
                begin
                    act = blps_pkg::ACT_REMOTE;
                    md  = cur_mode;
                    send_beat(act, md, 5'($urandom), $urandom_range(7) == 0, 1'b1);
                end
                else
                begin
                    md = 3'($urandom_range(blps_pkg::MODE_NORMAL));
                    cur_mode = md;
                    send_beat(blps_pkg::ACT_MODE, md, 5'($urandom), $urandom_range(7) == 0,
                              1'($urandom));
                end
            end
            else
            begin
                case ($urandom_range(2))
                    0:       send_beat(ACT_UNUSED, 3'($urandom), 5'($urandom), 1'($urandom),
                                       1'($urandom));
                    1:       send_beat(blps_pkg::ACT_MODE,
                                       3'($urandom_range(MODE_LAST, MODE_OTHER)),
                                       5'($urandom), 1'($urandom), 1'($urandom));
                    default: send_beat(blps_pkg::ACT_REMOTE, 3'($urandom), 5'($urandom),
                                       1'($urandom), 1'b0);
                endcase
            end
            burst = $urandom_range(6, 1);
            for (int t = 0; t < burst; t++)
            begin
                md = ($urandom_range(9) == 0) ? 3'($urandom) : cur_mode;
                send_beat(blps_pkg::ACT_TICK, md, 5'($urandom), $urandom_range(15) == 0,
                          1'($urandom));
            end
        end
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        start           = 1'b0;
        action          = blps_pkg::ACT_TICK;
        mode            = blps_pkg::MODE_INIT;
        error_bits      = '0;
        imu_preparing   = 1'b0;
        online          = 1'b0;
        mismatches      = 0;
        sender_idle_pct = 0;
        cur_mode        = blps_pkg::MODE_INIT;
        seq_running     = 1'b0;
        seq_timer       = 0;
        seq_index       = 0;
        seq_total       = 0;
        seq_pat         = blps_pkg::PAT_NONE;
        staged_len      = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_idle_events();
        test_fixed_patterns();
        test_error_patterns();
        test_pattern_end();
        test_random_traffic(11, 15);
        test_random_traffic(56, 15);
        test_random_traffic(0, 15);

        start <= 1'b0;
        for (int w = 0; w < 2000 && pending_cmds.size() != 0; w++)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pending_cmds.size() != 0)
        begin
            mismatches += pending_cmds.size();
            $display("%0t: expected %0d more results, got none", $time, pending_cmds.size());
        end
        if (mismatches == 0)
            $display("buzzer_led_pattern_sequencer_test: PASS");
        else
            $display("buzzer_led_pattern_sequencer_test: FAIL");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("buzzer_led_pattern_sequencer_test: FAIL");
        $finish;
    end

endmodule
